### src/gesc_pkg.sv
package gesc_pkg;

  localparam int MAX_ELEMENTS_DEF  = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;
  localparam int CNT_W             = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WR2,
    ST_EMIT,
    ST_DONE
  } gesc_state_t;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
  } gesc_mem_ctl_t;

endpackage

### src/gapped_exchange_sort_with_counts.sv
// Load: one element beat per cycle; busy stays low until the closing beat.
// Sort: each pair steps through READ and CMP, and WR2 too when it swaps (one
// write port, the two halves of a swap go in on separate cycles); a pass ends
// on a READ with no pair. Emit: results run back to back; idle right after.
// Throughput is one set at a time; the receiver cannot stall the strobe.
// Reset (sync, active low) clears control and totals; store contents undefined.
module gapped_exchange_sort_with_counts #(
  parameter int MAX_ELEMENTS  = gesc_pkg::MAX_ELEMENTS_DEF,
  parameter int ELEMENT_WIDTH = gesc_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [ELEMENT_WIDTH-1:0]   in_element,
  input  logic                              in_last_element,
  output logic                              out_valid,
  output logic signed [ELEMENT_WIDTH-1:0]   out_sorted_value,
  output logic                              out_final_value,
  output logic [gesc_pkg::CNT_W-1:0]        out_exchange_total,
  output logic [gesc_pkg::CNT_W-1:0]        out_comparison_total,
  output logic                              out_overflow_flag
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = $clog2(MAX_ELEMENTS + 1);

  gesc_pkg::gesc_mem_ctl_t  mem_ctl;
  logic [AW-1:0]            waddr, raddr_a, raddr_b;
  logic [ELEMENT_WIDTH-1:0] wdata, rdata_a, rdata_b;

  gesc_store #(
    .DW    (ELEMENT_WIDTH),
    .DEPTH (MAX_ELEMENTS),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .ctl     (mem_ctl),
    .waddr   (waddr),
    .wdata   (wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  gesc_seq #(
    .MAX_ELEMENTS  (MAX_ELEMENTS),
    .ELEMENT_WIDTH (ELEMENT_WIDTH),
    .AW            (AW),
    .CW            (CW)
  ) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .in_element      (in_element),
    .in_last_element (in_last_element),
    .busy            (busy),
    .mem_ctl         (mem_ctl),
    .waddr           (waddr),
    .wdata           (wdata),
    .raddr_a         (raddr_a),
    .raddr_b         (raddr_b),
    .rdata_a         (rdata_a),
    .rdata_b         (rdata_b),
    .emit_valid      (out_valid),
    .emit_last       (out_final_value),
    .exch_total      (out_exchange_total),
    .comp_total      (out_comparison_total),
    .dropped         (out_overflow_flag)
  );

  assign out_sorted_value = rdata_a;

endmodule

### src/gesc_store.sv
module gesc_store #(
  parameter int DW    = gesc_pkg::ELEMENT_WIDTH_DEF,
  parameter int DEPTH = gesc_pkg::MAX_ELEMENTS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  gesc_pkg::gesc_mem_ctl_t ctl,
  input  logic [AW-1:0]          waddr,
  input  logic [DW-1:0]          wdata,
  input  logic [AW-1:0]          raddr_a,
  input  logic [AW-1:0]          raddr_b,
  output logic [DW-1:0]          rdata_a,
  output logic [DW-1:0]          rdata_b
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while rd_en is low, so a pair stays put across a swap
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

### src/gesc_seq.sv
module gesc_seq #(
  parameter int MAX_ELEMENTS  = gesc_pkg::MAX_ELEMENTS_DEF,
  parameter int ELEMENT_WIDTH = gesc_pkg::ELEMENT_WIDTH_DEF,
  parameter int AW            = $clog2(MAX_ELEMENTS),
  parameter int CW            = $clog2(MAX_ELEMENTS + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [ELEMENT_WIDTH-1:0]    in_element,
  input  logic                        in_last_element,
  output logic                        busy,
  output gesc_pkg::gesc_mem_ctl_t     mem_ctl,
  output logic [AW-1:0]               waddr,
  output logic [ELEMENT_WIDTH-1:0]    wdata,
  output logic [AW-1:0]               raddr_a,
  output logic [AW-1:0]               raddr_b,
  input  logic [ELEMENT_WIDTH-1:0]    rdata_a,
  input  logic [ELEMENT_WIDTH-1:0]    rdata_b,
  output logic                        emit_valid,
  output logic                        emit_last,
  output logic [gesc_pkg::CNT_W-1:0]  exch_total,
  output logic [gesc_pkg::CNT_W-1:0]  comp_total,
  output logic                        dropped
);

  localparam int GW = CW - 1;

  gesc_pkg::gesc_state_t state_r, state_nxt;

  logic [CW-1:0]              count_r, count_nxt;
  logic [GW-1:0]              gap_r, gap_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic                       swap_r, swap_nxt;
  logic [gesc_pkg::CNT_W-1:0] exch_r, exch_nxt;
  logic [gesc_pkg::CNT_W-1:0] comp_r, comp_nxt;
  logic                       drop_r, drop_nxt;
  logic                       emit_pend_r, emit_pend_nxt;
  logic                       emit_last_r, emit_last_nxt;

  logic [CW:0]   pair_sum;
  logic          pair_ok;
  logic          full;
  logic [CW-1:0] cnt_after;
  logic          greater;

  assign pair_sum  = {1'b0, idx_r} + (CW + 1)'(gap_r);
  assign pair_ok   = pair_sum < {1'b0, count_r};
  assign full      = count_r == CW'(MAX_ELEMENTS);
  assign cnt_after = full ? count_r : count_r + CW'(1);
  assign greater   = $signed(rdata_a) > $signed(rdata_b);

  assign raddr_a = idx_r[AW-1:0];
  assign raddr_b = pair_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gesc_pkg::ST_IDLE;
      count_r     <= '0;
      gap_r       <= '0;
      idx_r       <= '0;
      swap_r      <= 1'b0;
      exch_r      <= '0;
      comp_r      <= '0;
      drop_r      <= 1'b0;
      emit_pend_r <= 1'b0;
      emit_last_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      gap_r       <= gap_nxt;
      idx_r       <= idx_nxt;
      swap_r      <= swap_nxt;
      exch_r      <= exch_nxt;
      comp_r      <= comp_nxt;
      drop_r      <= drop_nxt;
      emit_pend_r <= emit_pend_nxt;
      emit_last_r <= emit_last_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    gap_nxt       = gap_r;
    idx_nxt       = idx_r;
    swap_nxt      = swap_r;
    exch_nxt      = exch_r;
    comp_nxt      = comp_r;
    drop_nxt      = drop_r;
    emit_pend_nxt = 1'b0;
    emit_last_nxt = emit_last_r;
    mem_ctl       = '0;
    waddr         = idx_r[AW-1:0];
    wdata         = rdata_b;

    unique case (state_r)
      gesc_pkg::ST_IDLE: begin
        if (start) begin
          if (!full) begin
            mem_ctl.wr_en = 1'b1;
            waddr         = count_r[AW-1:0];
            wdata         = in_element;
            count_nxt     = cnt_after;
          end else begin
            drop_nxt = 1'b1;
          end
          if (in_last_element) begin
            gap_nxt   = cnt_after[CW-1:1];
            idx_nxt   = '0;
            swap_nxt  = 1'b0;
            state_nxt = gesc_pkg::ST_READ;
          end
        end
      end
      gesc_pkg::ST_READ: begin
        if (pair_ok) begin
          mem_ctl.rd_en = 1'b1;
          state_nxt     = gesc_pkg::ST_CMP;
        end else begin
          // end of a pass: repeat on a swap, else halve the gap, or emit once it would be 0
          idx_nxt  = '0;
          swap_nxt = 1'b0;
          if (!swap_r) begin
            if ((gap_r >> 1) == '0) begin
              state_nxt = gesc_pkg::ST_EMIT;
            end else begin
              gap_nxt = gap_r >> 1;
            end
          end
        end
      end
      gesc_pkg::ST_CMP: begin
        comp_nxt = (comp_r == '1) ? comp_r : comp_r + gesc_pkg::CNT_W'(1);
        if (greater) begin
          mem_ctl.wr_en = 1'b1;
          waddr         = idx_r[AW-1:0];
          wdata         = rdata_b;
          exch_nxt      = (exch_r == '1) ? exch_r : exch_r + gesc_pkg::CNT_W'(1);
          swap_nxt      = 1'b1;
          state_nxt     = gesc_pkg::ST_WR2;
        end else begin
          idx_nxt   = idx_r + CW'(1);
          state_nxt = gesc_pkg::ST_READ;
        end
      end
      gesc_pkg::ST_WR2: begin
        mem_ctl.wr_en = 1'b1;
        waddr         = pair_sum[AW-1:0];
        wdata         = rdata_a;
        idx_nxt       = idx_r + CW'(1);
        state_nxt     = gesc_pkg::ST_READ;
      end
      gesc_pkg::ST_EMIT: begin
        mem_ctl.rd_en = 1'b1;
        emit_pend_nxt = 1'b1;
        emit_last_nxt = idx_r == count_r - CW'(1);
        if (idx_r == count_r - CW'(1)) begin
          state_nxt = gesc_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + CW'(1);
        end
      end
      gesc_pkg::ST_DONE: begin
        // last beat is on the ports this cycle; totals clear behind it
        count_nxt = '0;
        gap_nxt   = '0;
        idx_nxt   = '0;
        swap_nxt  = 1'b0;
        exch_nxt  = '0;
        comp_nxt  = '0;
        drop_nxt  = 1'b0;
        state_nxt = gesc_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gesc_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy       = state_r != gesc_pkg::ST_IDLE;
  assign emit_valid = emit_pend_r;
  assign emit_last  = emit_last_r;
  assign exch_total = exch_r;
  assign comp_total = comp_r;
  assign dropped    = drop_r;

endmodule

### src/gesc_checker.sv
module gesc_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             start,
  input logic                             busy,
  input logic                             in_last_element,
  input logic                             out_valid,
  input logic                             out_final_value,
  input logic [gesc_pkg::CNT_W-1:0]       out_exchange_total,
  input logic [gesc_pkg::CNT_W-1:0]       out_comparison_total,
  input logic                             out_overflow_flag
);

  // results only come out while a set is in flight
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result beat while idle");

  // a non-closing load beat leaves the block idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_last_element) |=> !busy)
    else $error("busy after plain load beat");

  // results of a run are back to back
  a_burst: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final_value) |=> out_valid)
    else $error("gap inside result burst");

  a_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_final_value) |=> !out_valid)
    else $error("beat after final result");

  // run totals hold across the burst
  a_totals: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_final_value) |=>
      ($stable(out_exchange_total) && $stable(out_comparison_total)
       && $stable(out_overflow_flag)))
    else $error("totals changed inside burst");

endmodule

bind gapped_exchange_sort_with_counts gesc_checker u_gesc_checker (.*);
